/* rtl/kcl_pkg.sv */
// Package with the types, constants and event codes of the keypad code lock.
`timescale 1ns / 1ps
package kcl_pkg;

  localparam int MAX_ENTRY_DEF = 16;
  localparam int CFG_W         = 64;
  localparam int IDX_W         = 3;
  localparam int CNT_W         = 5;
  localparam int FAIL_W        = 8;
  localparam int TICK_W        = 24;
  localparam int KEY_W         = 8;

  localparam logic [KEY_W-1:0] KEY_CLEAR = 8'h43;
  localparam logic [KEY_W-1:0] KEY_ENTER = 8'h23;

  localparam logic [IDX_W-1:0] REG_CODE_LOW   = 3'd0;
  localparam logic [IDX_W-1:0] REG_CODE_HIGH  = 3'd1;
  localparam logic [IDX_W-1:0] REG_CODE_LEN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_FAIL_LIMIT = 3'd3;
  localparam logic [IDX_W-1:0] REG_LOCK_TICKS = 3'd4;
  localparam logic [IDX_W-1:0] REG_DOOR_TICKS = 3'd5;

  localparam logic [CFG_W-1:0]  RST_CODE_LOW   = 64'd875770417;
  localparam logic [CFG_W-1:0]  RST_CODE_HIGH  = 64'd0;
  localparam logic [CNT_W-1:0]  RST_CODE_LEN   = 5'd4;
  localparam logic [FAIL_W-1:0] RST_FAIL_LIMIT = 8'd3;
  localparam logic [TICK_W-1:0] RST_LOCK_TICKS = 24'd10000;
  localparam logic [TICK_W-1:0] RST_DOOR_TICKS = 24'd3000;

  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_STORED   = 3'd1,
    EV_DROPPED  = 3'd2,
    EV_CLEARED  = 3'd3,
    EV_ACCEPTED = 3'd4,
    EV_WRONG    = 3'd5,
    EV_LOCKED   = 3'd6,
    EV_UNLOCKED = 3'd7
  } kcl_event_t;

  typedef struct packed {
    logic [CFG_W-1:0]  code_low;
    logic [CFG_W-1:0]  code_high;
    logic [CNT_W-1:0]  code_length;
    logic [FAIL_W-1:0] fail_limit;
    logic [TICK_W-1:0] lockout_ticks;
    logic [TICK_W-1:0] door_hold_ticks;
  } kcl_cfg_t;

  typedef struct packed {
    kcl_event_t        event_res;
    logic              door_held;
    logic              locked;
    logic [CNT_W-1:0]  entry_length;
    logic [FAIL_W-1:0] attempts_left;
    logic [TICK_W-1:0] lockout_remaining;
  } kcl_result_t;

endpackage

/* rtl/kcl_cfg.sv */
// Configuration register file of the keypad code lock.
`timescale 1ns / 1ps
module kcl_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [kcl_pkg::IDX_W-1:0]   cfg_index,
  input  logic [kcl_pkg::CFG_W-1:0]   cfg_data,
  output kcl_pkg::kcl_cfg_t           cfg
);
  import kcl_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_low        <= RST_CODE_LOW;
      cfg.code_high       <= RST_CODE_HIGH;
      cfg.code_length     <= RST_CODE_LEN;
      cfg.fail_limit      <= RST_FAIL_LIMIT;
      cfg.lockout_ticks   <= RST_LOCK_TICKS;
      cfg.door_hold_ticks <= RST_DOOR_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CODE_LOW:   cfg.code_low        <= cfg_data;
        REG_CODE_HIGH:  cfg.code_high       <= cfg_data;
        REG_CODE_LEN:   cfg.code_length     <= cfg_data[CNT_W-1:0];
        REG_FAIL_LIMIT: cfg.fail_limit      <= cfg_data[FAIL_W-1:0];
        REG_LOCK_TICKS: cfg.lockout_ticks   <= cfg_data[TICK_W-1:0];
        REG_DOOR_TICKS: cfg.door_hold_ticks <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/kcl_core.sv */
// Lock state, entry buffer and the decision logic for one key or tick.
`timescale 1ns / 1ps
module kcl_core #(
  parameter int MAX_ENTRY = kcl_pkg::MAX_ENTRY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        action,
  input  logic [kcl_pkg::KEY_W-1:0]   key_code,
  input  kcl_pkg::kcl_cfg_t           cfg,
  output kcl_pkg::kcl_result_t        result
);
  import kcl_pkg::*;

  logic [KEY_W-1:0]  entry [MAX_ENTRY];
  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic [FAIL_W-1:0] fail_count, fail_count_next;
  logic [TICK_W-1:0] lockout_count, lockout_count_next;
  logic [TICK_W-1:0] door_count, door_count_next;
  logic [2*CFG_W-1:0] code_all;
  logic              chars_equal;
  logic              entry_match;
  logic              store;
  kcl_event_t        ev;

  assign code_all = {cfg.code_high, cfg.code_low};

  always_comb begin
    chars_equal = 1'b1;
    for (int i = 0; i < MAX_ENTRY; i++) begin
      if (CNT_W'(i) < entry_count && entry[i] != code_all[8*i +: 8]) begin
        chars_equal = 1'b0;
      end
    end
  end

  assign entry_match = (entry_count == cfg.code_length)
                    && (cfg.code_length <= CNT_W'(MAX_ENTRY)) && chars_equal;

  always_comb begin
    entry_count_next   = entry_count;
    fail_count_next    = fail_count;
    lockout_count_next = lockout_count;
    door_count_next    = door_count;
    store              = 1'b0;
    ev                 = EV_NONE;
    if (action == ACT_TICK) begin
      if (door_count != '0) begin
        door_count_next = door_count - 1'b1;
      end
      if (lockout_count != '0) begin
        lockout_count_next = lockout_count - 1'b1;
        if (lockout_count == TICK_W'(1)) begin
          fail_count_next = '0;
          ev              = EV_UNLOCKED;
        end
      end
    end else if (door_count != '0 || lockout_count != '0) begin
      ev = EV_DROPPED;
    end else if (key_code == KEY_CLEAR) begin
      entry_count_next = '0;
      ev               = EV_CLEARED;
    end else if (key_code == KEY_ENTER) begin
      entry_count_next = '0;
      if (entry_match) begin
        fail_count_next = '0;
        door_count_next = cfg.door_hold_ticks;
        ev              = EV_ACCEPTED;
      end else begin
        if (fail_count != '1) begin
          fail_count_next = fail_count + 1'b1;
        end
        ev = EV_WRONG;
        if (fail_count_next >= cfg.fail_limit) begin
          ev                 = EV_LOCKED;
          lockout_count_next = cfg.lockout_ticks;
          if (cfg.lockout_ticks == '0) begin
            fail_count_next = '0;
          end
        end
      end
    end else if (entry_count < CNT_W'(MAX_ENTRY)) begin
      store            = 1'b1;
      entry_count_next = entry_count + 1'b1;
      ev               = EV_STORED;
    end else begin
      ev = EV_DROPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      fail_count    <= '0;
      lockout_count <= '0;
      door_count    <= '0;
    end else if (step) begin
      entry_count   <= entry_count_next;
      fail_count    <= fail_count_next;
      lockout_count <= lockout_count_next;
      door_count    <= door_count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRY; i++) begin
      if (step && store && entry_count == CNT_W'(i)) begin
        entry[i] <= key_code;
      end
    end
  end

  always_comb begin
    result.event_res         = ev;
    result.door_held         = (door_count_next != '0);
    result.locked            = (lockout_count_next != '0);
    result.entry_length      = entry_count_next;
    result.attempts_left     = (cfg.fail_limit > fail_count_next)
                             ? cfg.fail_limit - fail_count_next : '0;
    result.lockout_remaining = lockout_count_next;
  end

endmodule

/* rtl/keypad_code_lock_with_lockout_top.sv */
// Keypad code lock with lockout: input register, decision core and result register.
// The core decides the word in the input register; the result register stores its result.
// Throughput: one word per cycle while results are taken; the core decides combinationally.
// While a result waits, the input register takes one more word and then holds the input off.
// Reset clears the entry, fail, lockout and door counters and loads the default code.
`timescale 1ns / 1ps
module keypad_code_lock_with_lockout_top #(
  parameter int MAX_ENTRY = kcl_pkg::MAX_ENTRY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        action,
  input  logic [kcl_pkg::KEY_W-1:0]   key_code,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  event_res,
  output logic                        door_held,
  output logic                        locked,
  output logic [kcl_pkg::CNT_W-1:0]   entry_length,
  output logic [kcl_pkg::FAIL_W-1:0]  attempts_left,
  output logic [kcl_pkg::TICK_W-1:0]  lockout_remaining,
  input  logic                        cfg_we,
  input  logic [kcl_pkg::IDX_W-1:0]   cfg_index,
  input  logic [kcl_pkg::CFG_W-1:0]   cfg_data
);
  import kcl_pkg::*;

  kcl_cfg_t    cfg;
  kcl_result_t result;
  kcl_result_t res_reg;
  logic        ir_valid;
  logic        ir_action;
  logic [KEY_W-1:0] ir_key;
  logic        step;

  assign step     = ir_valid && (!out_valid || out_ready);
  assign in_ready = !ir_valid || step;

  kcl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kcl_core #(
    .MAX_ENTRY (MAX_ENTRY)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .action   (ir_action),
    .key_code (ir_key),
    .cfg      (cfg),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        ir_valid <= in_valid;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ir_action <= action;
      ir_key    <= key_code;
    end
    if (step) begin
      res_reg <= result;
    end
  end

  assign event_res         = res_reg.event_res;
  assign door_held         = res_reg.door_held;
  assign locked            = res_reg.locked;
  assign entry_length      = res_reg.entry_length;
  assign attempts_left     = res_reg.attempts_left;
  assign lockout_remaining = res_reg.lockout_remaining;

endmodule

/* rtl/kcl_checker.sv */
// Port checker for the keypad code lock and its bind to the top level.
`timescale 1ns / 1ps
module kcl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [2:0]                  event_res,
  input logic                        door_held,
  input logic                        locked,
  input logic [kcl_pkg::CNT_W-1:0]   entry_length,
  input logic [kcl_pkg::TICK_W-1:0]  lockout_remaining
);
  import kcl_pkg::*;

  // A stalled result word must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res)
      && $stable(lockout_remaining))
    else $error("result word changed while stalled");

  // The door can never be open during a lockout.
  a_door_lock: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(door_held && locked))
    else $error("door open during lockout");

  // The locked flag follows the remaining lockout time.
  a_locked_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (locked == (lockout_remaining != '0)))
    else $error("locked flag disagrees with lockout time");

  // The end of a lockout leaves the lock free, with an entry that fits the buffer.
  a_unlock: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EV_UNLOCKED |-> !locked
      && entry_length <= CNT_W'(MAX_ENTRY_DEF))
    else $error("lockout ended but lock still busy");

endmodule

bind keypad_code_lock_with_lockout_top kcl_checker u_kcl_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .event_res         (event_res),
  .door_held         (door_held),
  .locked            (locked),
  .entry_length      (entry_length),
  .lockout_remaining (lockout_remaining)
);

/* bench/keypad_code_lock_with_lockout_top_tb.sv */
// Self-checking testbench for the keypad code lock: directed table, then random traffic.
`timescale 1ns / 1ps
module keypad_code_lock_with_lockout_top_tb;
  import kcl_pkg::*;

  localparam int MAX_ENTRY = MAX_ENTRY_DEF;
  localparam int ENT_IDX_W = $clog2(MAX_ENTRY);
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic              is_cfg;
    logic              act;
    logic [KEY_W-1:0]  key;
    logic [IDX_W-1:0]  idx;
    logic [CFG_W-1:0]  data;
    logic              typed;
    kcl_result_t       want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = ACT_KEY;
  logic [KEY_W-1:0] key_code = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] event_res;
  logic door_held;
  logic locked;
  logic [CNT_W-1:0] entry_length;
  logic [FAIL_W-1:0] attempts_left;
  logic [TICK_W-1:0] lockout_remaining;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  kcl_cfg_t cfg_shadow = {RST_CODE_LOW, RST_CODE_HIGH, RST_CODE_LEN, RST_FAIL_LIMIT,
                          RST_LOCK_TICKS, RST_DOOR_TICKS};
  logic [KEY_W-1:0]  ent_chars [MAX_ENTRY];
  logic [CNT_W-1:0]  ent_cnt = '0;
  logic [FAIL_W-1:0] fails = '0;
  logic [TICK_W-1:0] lock_cnt = '0;
  logic [TICK_W-1:0] door_cnt = '0;

  kcl_result_t pending_results[$];
  kcl_result_t oldest;
  plan_row_t   plan[$];
  int          err_count = 0;
  int          words_sent = 0;
  int          hold_len = 0;
  bit          quiet = 1'b0;

  keypad_code_lock_with_lockout_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .key_code(key_code),
    .out_valid(out_valid), .out_ready(out_ready), .event_res(event_res),
    .door_held(door_held), .locked(locked), .entry_length(entry_length),
    .attempts_left(attempts_left), .lockout_remaining(lockout_remaining),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_count++;
  endtask

  function automatic kcl_result_t predict_lock_result(input logic act, input logic [KEY_W-1:0] key);
    kcl_result_t r;
    kcl_event_t ev;
    logic hit;
    logic [2*CFG_W-1:0] code_all;
    ev = EV_NONE;
    code_all = {cfg_shadow.code_high, cfg_shadow.code_low};
    if (act == ACT_TICK) begin
      if (door_cnt != 0) door_cnt--;
      if (lock_cnt != 0) begin
        lock_cnt--;
        if (lock_cnt == 0) begin
          fails = '0;
          ev = EV_UNLOCKED;
        end
      end
    end else if (door_cnt != 0 || lock_cnt != 0) begin
      ev = EV_DROPPED;
    end else if (key == KEY_CLEAR) begin
      ent_cnt = '0;
      ev = EV_CLEARED;
    end else if (key == KEY_ENTER) begin
      hit = (ent_cnt == cfg_shadow.code_length) && (ent_cnt <= MAX_ENTRY);
      for (int i = 0; i < MAX_ENTRY; i++) begin
        if (i < ent_cnt && ent_chars[i] != code_all[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        fails = '0;
        door_cnt = cfg_shadow.door_hold_ticks;
        ev = EV_ACCEPTED;
      end else begin
        if (fails != 8'hFF) fails++;
        ev = EV_WRONG;
        if (fails >= cfg_shadow.fail_limit) begin
          ev = EV_LOCKED;
          lock_cnt = cfg_shadow.lockout_ticks;
          if (lock_cnt == 0) fails = '0;
        end
      end
      ent_cnt = '0;
    end else if (ent_cnt < MAX_ENTRY) begin
      ent_chars[ent_cnt[ENT_IDX_W-1:0]] = key;
      ent_cnt++;
      ev = EV_STORED;
    end else begin
      ev = EV_DROPPED;
    end
    r.event_res = ev;
    r.door_held = (door_cnt != 0);
    r.locked = (lock_cnt != 0);
    r.entry_length = ent_cnt;
    r.attempts_left = (cfg_shadow.fail_limit > fails) ? cfg_shadow.fail_limit - fails : '0;
    r.lockout_remaining = lock_cnt;
    return r;
  endfunction

  task automatic send_word(input logic act, input logic [KEY_W-1:0] key, input logic typed,
                           input kcl_result_t want);
    int gap;
    kcl_result_t predicted;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    key_code <= key;
    do @(posedge clk); while (!in_ready);
    predicted = predict_lock_result(act, key);
    pending_results.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_CODE_LOW:   cfg_shadow.code_low = data;
      REG_CODE_HIGH:  cfg_shadow.code_high = data;
      REG_CODE_LEN:   cfg_shadow.code_length = data[CNT_W-1:0];
      REG_FAIL_LIMIT: cfg_shadow.fail_limit = data[FAIL_W-1:0];
      REG_LOCK_TICKS: cfg_shadow.lockout_ticks = data[TICK_W-1:0];
      REG_DOOR_TICKS: cfg_shadow.door_hold_ticks = data[TICK_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void plan_key(input logic act, input logic [KEY_W-1:0] key);
    plan_row_t row;
    row = '0;
    row.act = act;
    row.key = key;
    plan.push_back(row);
  endfunction

  function automatic void plan_want(input logic act, input logic [KEY_W-1:0] key,
                                    input kcl_event_t ev, input logic dr, input logic lk,
                                    input logic [CNT_W-1:0] len, input logic [FAIL_W-1:0] att,
                                    input logic [TICK_W-1:0] rem);
    plan_row_t row;
    row = '0;
    row.act = act;
    row.key = key;
    row.typed = 1'b1;
    row.want = {ev, dr, lk, len, att, rem};
    plan.push_back(row);
  endfunction

  function automatic void plan_cfg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    plan.push_back(row);
  endfunction

  function automatic logic [CFG_W-1:0] digit_word();
    logic [CFG_W-1:0] w;
    for (int b = 0; b < 8; b++) w[8*b +: 8] = 8'h30 + KEY_W'($urandom_range(0, 9));
    return w;
  endfunction

  task automatic run_phase(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                           input logic [CNT_W-1:0] len, input logic [FAIL_W-1:0] lim,
                           input logic [TICK_W-1:0] lck, input logic [TICK_W-1:0] dr,
                           input int count, input int hold);
    int goal;
    int pick;
    int n;
    int code_n;
    int bad;
    logic [KEY_W-1:0] k;
    logic [2*CFG_W-1:0] code_all;
    logic [TICK_W-1:0] remaining;
    wait_idle();
    write_reg(REG_CODE_LOW, lo);
    write_reg(REG_CODE_HIGH, hi);
    write_reg(REG_CODE_LEN, len);
    write_reg(REG_FAIL_LIMIT, lim);
    write_reg(REG_LOCK_TICKS, lck);
    write_reg(REG_DOOR_TICKS, dr);
    if (hold > 0) begin
      quiet = 1'b1;
      hold_len = hold;
    end
    goal = words_sent + count;
    code_all = {hi, lo};
    code_n = (len > MAX_ENTRY) ? MAX_ENTRY : len;
    while (words_sent < goal) begin
      if (hold_len == 0 && $urandom_range(0, 19) == 0) quiet = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        bad = -1;
        if (code_n > 0 && $urandom_range(0, 7) == 0) bad = $urandom_range(0, code_n - 1);
        for (int i = 0; i < code_n; i++) begin
          k = code_all[8*i +: 8] ^ ((i == bad) ? 8'h01 : 8'h00);
          send_word(ACT_KEY, k, 1'b0, '0);
        end
        send_word(ACT_KEY, KEY_ENTER, 1'b0, '0);
      end else if (pick <= 5) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 6);
        repeat (n) begin
          k = KEY_W'($urandom);
          if (k == KEY_CLEAR || k == KEY_ENTER) k = k ^ 8'h10;
          send_word(ACT_KEY, k, 1'b0, '0);
        end
        send_word(ACT_KEY, $urandom_range(0, 1) ? KEY_ENTER : KEY_CLEAR, 1'b0, '0);
      end else if (pick <= 7) begin
        remaining = (door_cnt > lock_cnt) ? door_cnt : lock_cnt;
        n = (remaining != 0 && remaining <= 64) ? remaining : $urandom_range(1, 4);
        repeat (n) send_word(ACT_TICK, KEY_W'($urandom), 1'b0, '0);
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 5))
          send_word(1'($urandom_range(0, 1)), KEY_W'($urandom), 1'b0, '0);
      end else begin
        repeat ($urandom_range(1, 3)) send_word(ACT_KEY, KEY_ENTER, 1'b0, '0);
      end
    end
  endtask

  initial begin : result_sink
    int gap;
    wait (rst == 1'b0);
    forever begin
      if (hold_len > 0) begin
        gap = hold_len;
        hold_len = 0;
      end else begin
        gap = quiet ? 0 : $urandom_range(0, 12);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        oldest = pending_results.pop_front();
        if (event_res !== oldest.event_res)
          report_mismatch($sformatf("event_res %0d, expected %0d", event_res, oldest.event_res));
        if (door_held !== oldest.door_held)
          report_mismatch($sformatf("door_held %0b, expected %0b", door_held, oldest.door_held));
        if (locked !== oldest.locked)
          report_mismatch($sformatf("locked %0b, expected %0b", locked, oldest.locked));
        if (entry_length !== oldest.entry_length)
          report_mismatch($sformatf("entry_length %0d, expected %0d", entry_length,
                                    oldest.entry_length));
        if (attempts_left !== oldest.attempts_left)
          report_mismatch($sformatf("attempts_left %0d, expected %0d", attempts_left,
                                    oldest.attempts_left));
        if (lockout_remaining !== oldest.lockout_remaining)
          report_mismatch($sformatf("lockout_remaining %0d, expected %0d", lockout_remaining,
                                    oldest.lockout_remaining));
      end
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    plan_want(ACT_TICK, 8'h00, EV_NONE, 0, 0, 0, 3, 0);
    plan_want(ACT_KEY, 8'h00, EV_STORED, 0, 0, 1, 3, 0);
    plan_want(ACT_KEY, KEY_ENTER, EV_WRONG, 0, 0, 0, 2, 0);
    plan_cfg(REG_FAIL_LIMIT, 64'd2);
    plan_cfg(REG_LOCK_TICKS, 64'd2);
    plan_cfg(REG_DOOR_TICKS, 64'd1);
    plan_cfg(REG_CODE_LEN, 64'd2);
    plan_cfg(REG_CODE_LOW, 64'h3231);
    plan_key(ACT_KEY, 8'h31);
    plan_key(ACT_KEY, 8'h32);
    plan_want(ACT_KEY, KEY_ENTER, EV_ACCEPTED, 1, 0, 0, 2, 0);
    plan_want(ACT_KEY, KEY_CLEAR, EV_DROPPED, 1, 0, 0, 2, 0);
    plan_want(ACT_TICK, 8'hFF, EV_NONE, 0, 0, 0, 2, 0);
    plan_want(ACT_KEY, KEY_ENTER, EV_WRONG, 0, 0, 0, 1, 0);
    plan_want(ACT_KEY, KEY_ENTER, EV_LOCKED, 0, 1, 0, 0, 2);
    plan_want(ACT_KEY, 8'h31, EV_DROPPED, 0, 1, 0, 0, 2);
    plan_want(ACT_TICK, 8'h00, EV_NONE, 0, 1, 0, 0, 1);
    plan_want(ACT_TICK, 8'h00, EV_UNLOCKED, 0, 0, 0, 2, 0);
    plan_cfg(REG_DOOR_TICKS, 64'd0);
    plan_cfg(REG_LOCK_TICKS, 64'd0);
    plan_cfg(REG_FAIL_LIMIT, 64'd0);
    plan_cfg(REG_CODE_LEN, 64'd0);
    plan_want(ACT_KEY, KEY_ENTER, EV_ACCEPTED, 0, 0, 0, 0, 0);
    plan_key(ACT_KEY, 8'hFF);
    plan_want(ACT_KEY, KEY_ENTER, EV_LOCKED, 0, 0, 0, 0, 0);
    plan_want(ACT_KEY, KEY_CLEAR, EV_CLEARED, 0, 0, 0, 0, 0);
    plan_cfg(REG_CODE_LEN, 64'hFFFF_FFFF_FFFF_FFF1);
    plan_cfg(REG_FAIL_LIMIT, 64'hFFFF_FFFF_FFFF_FFFF);
    plan_cfg(REG_CODE_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    plan_cfg(REG_UNUSED, 64'd0);
    plan_want(ACT_KEY, KEY_ENTER, EV_WRONG, 0, 0, 0, 254, 0);

    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        wait_idle();
        write_reg(plan[r].idx, plan[r].data);
      end else begin
        send_word(plan[r].act, plan[r].key, plan[r].typed, plan[r].want);
      end
    end

    run_phase(digit_word(), digit_word(), 5'd4, 8'd3, 24'd20, 24'd5, 300, 300);
    run_phase({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 8'd1, 24'd1, 24'd1, 300, 0);
    run_phase(digit_word(), digit_word(), 5'd0, 8'd255, 24'd30, 24'd30, 200, 0);
    for (int p = 0; p < 5; p++) begin
      run_phase(p[0] ? {$urandom, $urandom} : digit_word(), digit_word(),
                CNT_W'($urandom_range(0, 16)), FAIL_W'($urandom_range(1, 8)),
                TICK_W'($urandom_range(1, 40)), TICK_W'($urandom_range(1, 40)), 220, 0);
    end
    run_phase(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 8'd1,
              24'hFF_FFFF, 24'hFF_FFFF, 60, 0);

    wait_idle();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
